[src/scpa_pkg.sv]
// shared constants, types and helpers for the size class pool allocator
`default_nettype none
package scpa_pkg;

	localparam int MAX_POOLS      = 10;
	localparam int PAGE_BYTES     = 4096;
	localparam int PAGES_PER_POOL = 16;
	localparam int MIN_OBJ_BYTES  = 16;

	localparam int LINK_DEPTH = (MAX_POOLS * PAGES_PER_POOL * PAGE_BYTES) / MIN_OBJ_BYTES;
	localparam int ARENA_END  = PAGE_BYTES + LINK_DEPTH * MIN_OBJ_BYTES;
	localparam int MIN_SHIFT  = $clog2(MIN_OBJ_BYTES);

	localparam int FUNC_W   = 2;
	localparam int SIZE_W   = 13;
	localparam int ADDR_W   = 20;
	localparam int STAT_W   = 3;
	localparam int PAGES_W  = 5;
	localparam int CNT_W    = 13;
	localparam int BYTES_W  = 17;
	localparam int LIM_W    = 5;
	localparam int POOL_W   = $clog2(MAX_POOLS);
	localparam int PCNT_W   = $clog2(MAX_POOLS + 1);
	localparam int SLOTS_W  = $clog2(PAGE_BYTES / MIN_OBJ_BYTES + 1);
	localparam int OFF_W    = $clog2(PAGE_BYTES + 1);
	localparam int LIDX_W   = $clog2(LINK_DEPTH);
	localparam int TOT_W    = PAGES_W + SLOTS_W;
	localparam int AB_W     = CNT_W + SIZE_W;

	localparam logic [CNT_W-1:0]   COUNT_MAX = '1;
	localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

	typedef enum logic [FUNC_W-1:0] {
		FN_ALLOC = 2'd0,
		FN_FREE  = 2'd1,
		FN_STATS = 2'd2,
		FN_RESET = 2'd3
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_LIMIT   = 3'd2,
		ST_IGNORED = 3'd3,
		ST_UNDER   = 3'd4
	} status_t;

	typedef struct packed {
		status_t             status;
		logic [ADDR_W-1:0]   address_out;
		logic [PAGES_W-1:0]  pool_pages;
		logic [CNT_W-1:0]    live_objs;
		logic [CNT_W-1:0]    idle_objs;
		logic [BYTES_W-1:0]  pool_bytes;
		logic [BYTES_W-1:0]  live_bytes;
	} rsp_t;

	function automatic logic [LIDX_W-1:0] link_idx(input logic [ADDR_W-1:0] a);
		logic [ADDR_W-1:0] d;
		d = a - ADDR_W'(PAGE_BYTES);
		return LIDX_W'(d >> MIN_SHIFT);
	endfunction

endpackage
`default_nettype wire

[src/scpa_link_ram.sv]
// single port write, single port read ram with registered read data
`default_nettype none
module scpa_link_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[src/scpa_ctrl.sv]
// request sequencer, pool table and free list link memory control
`default_nettype none
module scpa_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [scpa_pkg::LIM_W-1:0]    cfg_wdata,
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire logic [scpa_pkg::FUNC_W-1:0]   req_func,
	input  wire logic [scpa_pkg::SIZE_W-1:0]   req_size,
	input  wire logic [scpa_pkg::ADDR_W-1:0]   req_addr,
	output logic                               rsp_valid,
	input  wire logic                          rsp_take,
	output scpa_pkg::rsp_t                     rsp
);

	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_FILL, S_POP, S_POPW, S_STAT, S_DONE
	} state_t;

	state_t state_q;

	logic [scpa_pkg::FUNC_W-1:0]   func_q;
	logic [scpa_pkg::SIZE_W-1:0]   size_q;
	logic [scpa_pkg::ADDR_W-1:0]   addr_q;
	logic [scpa_pkg::POOL_W-1:0]   pool_q;
	logic [scpa_pkg::LIM_W-1:0]    page_limit_q;
	logic [scpa_pkg::PCNT_W-1:0]   pool_count_q;
	logic [scpa_pkg::OFF_W-1:0]    fill_off_q;
	logic [scpa_pkg::SLOTS_W-1:0]  fill_cnt_q;
	logic [scpa_pkg::ADDR_W-1:0]   fill_base_q;

	logic [scpa_pkg::SIZE_W-1:0]   size_tab  [scpa_pkg::MAX_POOLS];
	logic [scpa_pkg::SLOTS_W-1:0]  slots_tab [scpa_pkg::MAX_POOLS];
	logic [scpa_pkg::PAGES_W-1:0]  pages_q   [scpa_pkg::MAX_POOLS];
	logic [scpa_pkg::CNT_W-1:0]    cnt_q     [scpa_pkg::MAX_POOLS];
	logic [scpa_pkg::ADDR_W-1:0]   head_q    [scpa_pkg::MAX_POOLS];

	logic [scpa_pkg::TOT_W-1:0]    tot_s1;
	logic [scpa_pkg::AB_W-1:0]     ab_s1;
	logic [scpa_pkg::PAGES_W-1:0]  pages_s1;
	logic [scpa_pkg::CNT_W-1:0]    cnt_s1;

	scpa_pkg::rsp_t res_q;

	// pool lookup
	logic                          hit;
	logic [scpa_pkg::POOL_W-1:0]   hit_idx;
	logic                          full;
	logic [scpa_pkg::POOL_W-1:0]   cur_pool;
	logic [scpa_pkg::ADDR_W-1:0]   cur_head;
	logic [scpa_pkg::PAGES_W-1:0]  cur_pages;
	logic [scpa_pkg::CNT_W-1:0]    cur_cnt;
	logic [scpa_pkg::PAGES_W-1:0]  lim;
	logic                          addr_ok;
	logic                          create_en;
	logic                          slots_we;
	logic [scpa_pkg::ADDR_W-1:0]   fill_addr;
	logic [scpa_pkg::OFF_W:0]      off_next;
	logic [scpa_pkg::OFF_W+1:0]    off_end;
	logic                          fill_more;
	logic [scpa_pkg::SIZE_W-1:0]   sat_size;

	logic                          mem_we;
	logic [scpa_pkg::LIDX_W-1:0]   mem_waddr;
	logic [scpa_pkg::ADDR_W-1:0]   mem_wdata;
	logic                          mem_re;
	logic [scpa_pkg::LIDX_W-1:0]   mem_raddr;
	logic [scpa_pkg::ADDR_W-1:0]   mem_rdata;

	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		for (int i = scpa_pkg::MAX_POOLS - 1; i >= 0; i--) begin
			if (scpa_pkg::PCNT_W'(i) < pool_count_q && size_tab[i] == size_q) begin
				hit = 1'b1;
				hit_idx = scpa_pkg::POOL_W'(i);
			end
		end
		full = pool_count_q >= scpa_pkg::PCNT_W'(scpa_pkg::MAX_POOLS);
		cur_pool = hit ? hit_idx : scpa_pkg::POOL_W'(pool_count_q);
		cur_head = hit ? head_q[hit_idx] : '0;
		cur_pages = hit ? pages_q[hit_idx] : '0;
		cur_cnt = hit ? cnt_q[hit_idx] : '0;
		lim = (page_limit_q > scpa_pkg::LIM_W'(scpa_pkg::PAGES_PER_POOL))
			? scpa_pkg::PAGES_W'(scpa_pkg::PAGES_PER_POOL) : page_limit_q;
		addr_ok = addr_q >= scpa_pkg::ADDR_W'(scpa_pkg::PAGE_BYTES)
			&& addr_q < scpa_pkg::ADDR_W'(scpa_pkg::ARENA_END);
	end

	always_comb begin
		sat_size = req_size;
		if (req_size < scpa_pkg::SIZE_W'(scpa_pkg::MIN_OBJ_BYTES)) begin
			sat_size = scpa_pkg::SIZE_W'(scpa_pkg::MIN_OBJ_BYTES);
		end else if (req_size > scpa_pkg::SIZE_W'(scpa_pkg::PAGE_BYTES)) begin
			sat_size = scpa_pkg::SIZE_W'(scpa_pkg::PAGE_BYTES);
		end
	end

	assign fill_addr = fill_base_q + scpa_pkg::ADDR_W'(fill_off_q);
	assign off_next  = (scpa_pkg::OFF_W+1)'(fill_off_q) + (scpa_pkg::OFF_W+1)'(size_q);
	assign off_end   = (scpa_pkg::OFF_W+2)'(off_next) + (scpa_pkg::OFF_W+2)'(size_q);
	assign fill_more = off_end <= (scpa_pkg::OFF_W+2)'(scpa_pkg::PAGE_BYTES);

	assign create_en = state_q == S_EXEC && func_q != scpa_pkg::FN_RESET
		&& !(func_q == scpa_pkg::FN_FREE && addr_q == '0) && !hit && !full;
	assign slots_we = state_q == S_FILL && !fill_more;

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = scpa_pkg::link_idx(fill_addr);
		mem_wdata = head_q[pool_q];
		if (state_q == S_FILL) begin
			mem_we = 1'b1;
		end else if (state_q == S_EXEC && func_q == scpa_pkg::FN_FREE && addr_q != '0
				&& (hit || !full) && addr_ok) begin
			mem_we = 1'b1;
			mem_waddr = scpa_pkg::link_idx(addr_q);
			mem_wdata = cur_head;
		end
		mem_re = state_q == S_POP;
		mem_raddr = scpa_pkg::link_idx(head_q[pool_q]);
	end

	scpa_link_ram #(
		.DEPTH(scpa_pkg::LINK_DEPTH),
		.WIDTH(scpa_pkg::ADDR_W)
	) u_link_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// pool keys and slot counts have no reset value
	always_ff @(posedge clk) begin
		if (create_en) begin
			size_tab[cur_pool] <= size_q;
		end
		if (slots_we) begin
			slots_tab[pool_q] <= fill_cnt_q + scpa_pkg::SLOTS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		tot_s1   <= scpa_pkg::TOT_W'(cur_pages * slots_tab[cur_pool]);
		ab_s1    <= scpa_pkg::AB_W'(cur_cnt * size_q);
		pages_s1 <= cur_pages;
		cnt_s1   <= cur_cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			page_limit_q <= scpa_pkg::LIM_W'(scpa_pkg::PAGES_PER_POOL);
			pool_count_q <= '0;
			for (int i = 0; i < scpa_pkg::MAX_POOLS; i++) begin
				pages_q[i] <= '0;
				cnt_q[i] <= '0;
				head_q[i] <= '0;
			end
			func_q <= '0;
			size_q <= '0;
			addr_q <= '0;
			pool_q <= '0;
			fill_off_q <= '0;
			fill_cnt_q <= '0;
			fill_base_q <= '0;
			res_q <= '0;
		end else begin
			if (cfg_we) begin
				page_limit_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						func_q <= req_func;
						size_q <= sat_size;
						addr_q <= req_addr;
						res_q <= '0;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
					if (func_q == scpa_pkg::FN_RESET) begin
						pool_count_q <= '0;
						for (int i = 0; i < scpa_pkg::MAX_POOLS; i++) begin
							pages_q[i] <= '0;
							cnt_q[i] <= '0;
							head_q[i] <= '0;
						end
					end else if (func_q == scpa_pkg::FN_FREE && addr_q == '0) begin
						res_q.status <= scpa_pkg::ST_IGNORED;
					end else if (!hit && full) begin
						res_q.status <= scpa_pkg::ST_FULL;
					end else begin
						pool_q <= cur_pool;
						if (!hit) begin
							pool_count_q <= pool_count_q + scpa_pkg::PCNT_W'(1);
							pages_q[cur_pool] <= '0;
							cnt_q[cur_pool] <= '0;
							if (!(func_q == scpa_pkg::FN_FREE && addr_ok)) begin
								head_q[cur_pool] <= '0;
							end
						end
						case (func_q)
							scpa_pkg::FN_ALLOC: begin
								if (cur_head != '0) begin
									state_q <= S_POP;
								end else if (cur_pages >= lim) begin
									res_q.status <= scpa_pkg::ST_LIMIT;
								end else begin
									fill_off_q <= '0;
									fill_cnt_q <= '0;
									fill_base_q <= scpa_pkg::ADDR_W'(
										(int'(cur_pool) * scpa_pkg::PAGES_PER_POOL
										+ int'(cur_pages) + 1) * scpa_pkg::PAGE_BYTES);
									state_q <= S_FILL;
								end
							end
							scpa_pkg::FN_FREE: begin
								if (!addr_ok) begin
									res_q.status <= scpa_pkg::ST_IGNORED;
								end else begin
									head_q[cur_pool] <= addr_q;
									if (cur_cnt == '0) begin
										res_q.status <= scpa_pkg::ST_UNDER;
									end else begin
										cnt_q[cur_pool] <= cur_cnt - scpa_pkg::CNT_W'(1);
									end
								end
							end
							default: begin
								if (cur_pages != '0) begin
									state_q <= S_STAT;
								end
							end
						endcase
					end
				end
				S_FILL: begin
					head_q[pool_q] <= fill_addr;
					fill_off_q <= scpa_pkg::OFF_W'(off_next);
					fill_cnt_q <= fill_cnt_q + scpa_pkg::SLOTS_W'(1);
					if (!fill_more) begin
						pages_q[pool_q] <= pages_q[pool_q] + scpa_pkg::PAGES_W'(1);
						state_q <= S_POP;
					end
				end
				S_POP: begin
					state_q <= S_POPW;
				end
				S_POPW: begin
					res_q.address_out <= head_q[pool_q];
					head_q[pool_q] <= mem_rdata;
					if (cnt_q[pool_q] != scpa_pkg::COUNT_MAX) begin
						cnt_q[pool_q] <= cnt_q[pool_q] + scpa_pkg::CNT_W'(1);
					end
					state_q <= S_DONE;
				end
				S_STAT: begin
					res_q.pool_pages <= pages_s1;
					res_q.live_objs <= cnt_s1;
					res_q.idle_objs <= (tot_s1 > scpa_pkg::TOT_W'(cnt_s1))
						? scpa_pkg::CNT_W'(tot_s1 - scpa_pkg::TOT_W'(cnt_s1)) : '0;
					res_q.pool_bytes <= scpa_pkg::BYTES_W'(pages_s1)
						<< $clog2(scpa_pkg::PAGE_BYTES);
					res_q.live_bytes <= (ab_s1 > scpa_pkg::AB_W'(scpa_pkg::BYTES_MAX))
						? scpa_pkg::BYTES_MAX : scpa_pkg::BYTES_W'(ab_s1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = state_q == S_DONE;
	assign rsp = res_q;

	a_pool_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pool_count_q <= scpa_pkg::PCNT_W'(scpa_pkg::MAX_POOLS))
		else $error("pool count above table size");

	a_fill_in_page: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FILL |-> off_next <= (scpa_pkg::OFF_W+1)'(scpa_pkg::PAGE_BYTES))
		else $error("fill slot runs past page end");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POP |-> head_q[pool_q] != '0)
		else $error("pop from empty free list");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> !mem_we)
		else $error("link read and write in same cycle");

endmodule
`default_nettype wire

[src/size_class_pool_allocator.sv]
// top level: size class pool allocator with output register
//
// channel  | handshake          | payload
// config   | cfg_we             | cfg_wdata
// request  | in_valid, in_stall | func, size_bytes, address_in
// result   | out_valid, out_stall | status, address_out, statistics
//
// each request runs to its result before the next is taken; alloc into
// an empty list first pushes every slot of a new page (up to 256), one
// link memory write a cycle. the single write port sets the rate.
// reset clears the pool table at once; link memory needs no clearing.
// a result waits in the output register while the next request is taken.
`default_nettype none
module size_class_pool_allocator (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [scpa_pkg::LIM_W-1:0]        cfg_wdata,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [scpa_pkg::FUNC_W-1:0]       func,
	input  wire logic [scpa_pkg::SIZE_W-1:0]       size_bytes,
	input  wire logic [scpa_pkg::ADDR_W-1:0]       address_in,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [scpa_pkg::STAT_W-1:0]            status,
	output logic [scpa_pkg::ADDR_W-1:0]            address_out,
	output logic [scpa_pkg::PAGES_W-1:0]           pool_pages,
	output logic [scpa_pkg::CNT_W-1:0]             live_objs,
	output logic [scpa_pkg::CNT_W-1:0]             idle_objs,
	output logic [scpa_pkg::BYTES_W-1:0]           pool_bytes,
	output logic [scpa_pkg::BYTES_W-1:0]           live_bytes
);

	logic           rsp_valid;
	logic           rsp_take;
	scpa_pkg::rsp_t rsp;
	logic           out_valid_q;
	scpa_pkg::rsp_t out_q;

	scpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (in_valid),
		.req_stall (in_stall),
		.req_func  (func),
		.req_size  (size_bytes),
		.req_addr  (address_in),
		.rsp_valid (rsp_valid),
		.rsp_take  (rsp_take),
		.rsp       (rsp)
	);

	assign rsp_take = rsp_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rsp_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_take) begin
			out_q <= rsp;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign address_out = out_q.address_out;
	assign pool_pages  = out_q.pool_pages;
	assign live_objs   = out_q.live_objs;
	assign idle_objs   = out_q.idle_objs;
	assign pool_bytes  = out_q.pool_bytes;
	assign live_bytes  = out_q.live_bytes;

endmodule
`default_nettype wire
